[design/assert_macros.svh]
// Assertion macros shared by the interpolator RTL.
// Depends on a clock named clk and an active-high reset named rst in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off during reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[design/pli_pkg.sv]
// Package for the piecewise linear interpolator: sizes, codes and sequencer states.
// No dependencies; used by pli_div and piecewise_linear_interpolator.
package pli_pkg;

  localparam int MAX_POINTS = 128;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int DATA_W     = 16;
  localparam int WORD_W     = 2 * DATA_W;
  localparam int PC_W       = 8;
  localparam logic [PC_W-1:0] PC_RESET = PC_W'(128);

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_QUERY = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    KIND_BELOW  = 2'd0,
    KIND_INTERP = 2'd1,
    KIND_ABOVE  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PREP,
    ST_DIV,
    ST_MUL,
    ST_SUM,
    ST_FIN
  } state_t;

  // Handshake between the sequencer and the fraction divider
  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quotient;
  } div_rsp_t;

endpackage

[design/pli_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module pli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/pli_div.sv]
// Restoring divider for the Q0.16 segment fraction: (dividend << 16) / divisor, one bit a cycle.
// Depends on pli_pkg and assert_macros.svh; dividend must be below divisor.
`include "assert_macros.svh"

module pli_div
  import pli_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(DATA_W + 1);

  logic [DATA_W:0]     rem;
  logic [DATA_W-1:0]   quo;
  logic [CNT_W-1:0]    cnt;
  logic                busy;
  logic                done;
  logic [DATA_W:0]     trial;
  logic                take;

  // Shift the partial remainder and test against the divisor
  assign trial = {rem[DATA_W-1:0], 1'b0};
  assign take  = trial >= {1'b0, req.divisor};

  // Control: count quotient bits, pulse done after the last one
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DATA_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= {1'b0, req.dividend};
      quo <= '0;
    end else if (busy) begin
      rem <= take ? (trial - {1'b0, req.divisor}) : trial;
      quo <= {quo[DATA_W-2:0], take};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

  `ASSERT_SAME(a_busy_count, busy, cnt != '0, "divider busy with zero count")
  `ASSERT_NEXT(a_done_once, done, !done, "divider done held for two cycles")

endmodule

[design/piecewise_linear_interpolator.sv]
// Piecewise linear interpolator: breakpoint table in one RAM, scan, divide, multiply, add.
// Depends on pli_pkg, pli_ram, pli_div and assert_macros.svh.
//
// A load (action 0) writes one breakpoint into the table RAM.
// A query (action 1) scans the table from the last point in use downward, one
// entry per cycle through the RAM read port, until it finds an x at or below
// the query; the entry above it was read the cycle before, so no second read
// is needed. At the table ends the scan result goes straight to the output
// register. An interpolated query passes through set-up, the bit-serial
// divider for the Q0.16 fraction, the multiplier, the add and saturate, and
// the hand-over of the item to the output register. The sequencer accepts
// items only when idle, and all table writes happen in that state, so a scan
// read never overlaps a write to the same entry. The output register lets the
// next item enter while a result waits. point_count below 2 acts as 2; the
// table holds whatever was loaded, and entries never loaded read back undefined.
`include "assert_macros.svh"

module piecewise_linear_interpolator
  import pli_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [PC_W-1:0]          cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     action,
  input  logic [6:0]               point_index,
  input  logic signed [DATA_W-1:0] point_x,
  input  logic signed [DATA_W-1:0] point_y,
  input  logic signed [DATA_W-1:0] query_x,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [DATA_W-1:0] value_y,
  output logic [1:0]               segment_kind
);

  state_t state, state_next;

  logic [PC_W-1:0]          point_count;
  logic [IDX_W-1:0]         last_idx;
  logic [IDX_W-1:0]         last_q;
  logic [IDX_W-1:0]         scan_idx;
  logic signed [DATA_W-1:0] q;
  logic signed [DATA_W-1:0] prev_x, prev_y;
  logic signed [DATA_W-1:0] lo_x, lo_y, hi_x, hi_y;
  logic signed [DATA_W:0]   dy;
  logic signed [2*DATA_W+1:0] prod;
  logic signed [DATA_W-1:0] res_y;
  kind_t                    res_kind;

  logic                     ram_we;
  logic [IDX_W-1:0]         ram_raddr;
  logic [WORD_W-1:0]        ram_rdata;
  logic signed [DATA_W-1:0] rd_x, rd_y;
  logic                     hit;
  logic signed [DATA_W:0]   gap;
  logic                     gap_pos;
  logic [DATA_W:0]          rel_x;
  logic signed [DATA_W+1:0] sum;
  logic                     out_free;
  logic                     in_fire;
  logic                     query_fire;
  div_req_t                 div_req;
  div_rsp_t                 div_rsp;

  // Clamp the point count to between 2 and the table size
  always_comb begin
    priority if (point_count < PC_W'(2)) begin
      last_idx = IDX_W'(1);
    end else if (32'(point_count) > MAX_POINTS) begin
      last_idx = IDX_W'(MAX_POINTS - 1);
    end else begin
      last_idx = IDX_W'(point_count - PC_W'(1));
    end
  end

  assign in_fire    = in_valid && in_ready;
  assign query_fire = in_fire && (action == ACT_QUERY);
  assign ram_we     = in_fire && (action == ACT_LOAD) && (32'(point_index) < MAX_POINTS);
  assign out_free   = !out_valid || out_ready;

  pli_ram #(
    .WIDTH(WORD_W),
    .DEPTH(MAX_POINTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (IDX_W'(point_index)),
    .wdata ({point_x, point_y}),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_x = ram_rdata[WORD_W-1:DATA_W];
  assign rd_y = ram_rdata[DATA_W-1:0];
  assign hit  = q >= rd_x;

  // Segment set-up arithmetic
  assign gap     = {hi_x[DATA_W-1], hi_x} - {lo_x[DATA_W-1], lo_x};
  assign gap_pos = !gap[DATA_W] && (gap != '0);
  assign rel_x   = {q[DATA_W-1], q} - {lo_x[DATA_W-1], lo_x};

  // Floor of product / 2^16 by arithmetic shift, then add the lower y
  assign sum = {{2{lo_y[DATA_W-1]}}, lo_y} + prod[2*DATA_W+1:DATA_W];

  assign div_req.start    = (state == ST_PREP) && gap_pos;
  assign div_req.dividend = rel_x[DATA_W-1:0];
  assign div_req.divisor  = gap[DATA_W-1:0];

  pli_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (query_fire) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        priority if (hit) begin
          state_next = (scan_idx == last_q) ? ST_FIN : ST_PREP;
        end else if (scan_idx == '0) begin
          state_next = ST_FIN;
        end
      end
      ST_PREP: begin
        state_next = gap_pos ? ST_DIV : ST_FIN;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_next = ST_MUL;
        end
      end
      ST_MUL:  state_next = ST_SUM;
      ST_SUM:  state_next = ST_FIN;
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: input handshake and RAM read address
  always_comb begin
    in_ready  = 1'b0;
    ram_raddr = last_idx;
    unique case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        ram_raddr = last_idx;
      end
      ST_SCAN: ram_raddr = scan_idx - IDX_W'(1);
      default: ram_raddr = last_idx;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      point_count <= PC_RESET;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        point_count <= cfg_wdata;
      end
      if (state == ST_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (query_fire) begin
          q        <= query_x;
          last_q   <= last_idx;
          scan_idx <= last_idx;
        end
      end
      ST_SCAN: begin
        prev_x <= rd_x;
        prev_y <= rd_y;
        priority if (hit) begin
          lo_x     <= rd_x;
          lo_y     <= rd_y;
          hi_x     <= prev_x;
          hi_y     <= prev_y;
          res_y    <= rd_y;
          res_kind <= KIND_ABOVE;
        end else if (scan_idx == '0) begin
          res_y    <= rd_y;
          res_kind <= KIND_BELOW;
        end else begin
          scan_idx <= scan_idx - IDX_W'(1);
        end
      end
      ST_PREP: begin
        res_kind <= KIND_INTERP;
        res_y    <= lo_y;
        dy       <= {hi_y[DATA_W-1], hi_y} - {lo_y[DATA_W-1], lo_y};
      end
      ST_MUL: begin
        prod <= (2*DATA_W+2)'(dy * $signed({1'b0, div_rsp.quotient}));
      end
      ST_SUM: begin
        priority if (sum > (DATA_W+2)'(32767)) begin
          res_y <= DATA_W'(32767);
        end else if (sum < -(DATA_W+2)'(32768)) begin
          res_y <= DATA_W'(-32768);
        end else begin
          res_y <= sum[DATA_W-1:0];
        end
      end
      ST_FIN: begin
        if (out_free) begin
          value_y      <= res_y;
          segment_kind <= res_kind;
        end
      end
      default: begin
      end
    endcase
  end

  `ASSERT_NEXT(a_scan_step, state == ST_SCAN && !hit && scan_idx != '0,
               state == ST_SCAN && scan_idx == $past(scan_idx) - IDX_W'(1),
               "scan did not step down")
  `ASSERT_SAME(a_scan_range, state == ST_SCAN, scan_idx <= last_q,
               "scan index above last point")
  `ASSERT_SAME(a_div_owner, div_rsp.done, state == ST_DIV,
               "divider finished outside divide state")
  `ASSERT_NEXT(a_fin_hand, state == ST_FIN && out_free, out_valid && state == ST_IDLE,
               "result not handed to output")
  `ASSERT_SAME(a_no_write_busy, ram_we, state == ST_IDLE,
               "table written while sequencer busy")

endmodule
